// ===== hdl/switch_press_mode_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Switch press mode controller: assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SWITCH_PRESS_MODE_CONTROLLER_UNIT_MACROS_SVH
`define SWITCH_PRESS_MODE_CONTROLLER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPMC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Switch press mode controller package
// Field widths, switch codes, register indexes, state and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package spmc_pkg;

  localparam int SwW     = 2;
  localparam int TimeW   = 32;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 1;
  localparam int LedW    = 6;
  localparam int CountW  = 3;
  localparam int ModeW   = 3;

  localparam logic [SwW-1:0] SW_UP   = 2'd0;
  localparam logic [SwW-1:0] SW_MID  = 2'd1;
  localparam logic [SwW-1:0] SW_DOWN = 2'd2;
  localparam logic [SwW-1:0] SW_BAD  = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_LED_HOLD   = 1'd1;

  localparam logic [CfgW-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [CfgW-1:0] LED_HOLD_RST   = 16'd500;

  localparam logic [CountW-1:0] MAX_NOTES = 3'd6;
  localparam logic [ModeW-1:0]  LAST_MODE = 3'd6;

  typedef struct packed {
    logic              primed;
    logic [SwW-1:0]    prev_sw;
    logic              short_pending;
    logic              long_consumed;
    logic              press_timing;
    logic [TimeW-1:0]  press_start;
    logic [CountW-1:0] note_count;
    logic              limit_on;
    logic [ModeW-1:0]  mode;
    logic              hold_running;
    logic [TimeW-1:0]  hold_end;
    logic [TimeW-1:0]  change_stamp;
  } state_t;

  typedef struct packed {
    logic              led_write;
    logic [LedW-1:0]   led_bits;
    logic              fixed_length_on;
    logic [CountW-1:0] fixed_length;
    logic [ModeW-1:0]  dir_mode;
    logic              mode_pulse;
    logic              hold_busy;
    logic [TimeW-1:0]  last_change_ms;
  } result_t;

  // Note count shown as a bar of lit LEDs; out-of-range counts show all six.
  function automatic logic [LedW-1:0] bar_of(input logic [CountW-1:0] n);
    logic [LedW-1:0] bar;
    case (n)
      3'd1:    bar = 6'b000001;
      3'd2:    bar = 6'b000011;
      3'd3:    bar = 6'b000111;
      3'd4:    bar = 6'b001111;
      3'd5:    bar = 6'b011111;
      default: bar = 6'b111111;
    endcase
    return bar;
  endfunction

  function automatic logic [LedW-1:0] mode_leds(input logic [ModeW-1:0] m);
    logic [LedW-1:0] pat;
    case (m)
      3'd0:    pat = 6'b000001;
      3'd1:    pat = 6'b010000;
      3'd2:    pat = 6'b000011;
      3'd3:    pat = 6'b110000;
      3'd4:    pat = 6'b010010;
      3'd5:    pat = 6'b100001;
      3'd6:    pat = 6'b011001;
      default: pat = 6'b000001;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/spmc_if.sv =====
// ----------------------------------------------------------------------------
// Switch press mode controller channel interfaces
// Valid/ready channels for switch polls and for poll results.
// ----------------------------------------------------------------------------
`default_nettype none

interface spmc_in_if;
  logic                          valid;
  logic                          ready;
  logic [spmc_pkg::SwW-1:0]      switch_position;
  logic [spmc_pkg::TimeW-1:0]    now_ms;

  modport source (output valid, output switch_position, output now_ms, input ready);
  modport sink   (input valid, input switch_position, input now_ms, output ready);
endinterface

interface spmc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          led_write;
  logic [spmc_pkg::LedW-1:0]     led_bits;
  logic                          fixed_length_on;
  logic [spmc_pkg::CountW-1:0]   fixed_length;
  logic [spmc_pkg::ModeW-1:0]    dir_mode;
  logic                          mode_pulse;
  logic                          hold_busy;
  logic [spmc_pkg::TimeW-1:0]    last_change_ms;

  modport source (output valid, output led_write, output led_bits,
                  output fixed_length_on, output fixed_length, output dir_mode,
                  output mode_pulse, output hold_busy,
                  output last_change_ms, input ready);
  modport sink   (input valid, input led_write, input led_bits,
                  input fixed_length_on, input fixed_length, input dir_mode,
                  input mode_pulse, input hold_busy,
                  input last_change_ms, output ready);
endinterface

`default_nettype wire

// ===== hdl/spmc_step.sv =====
// ----------------------------------------------------------------------------
// Switch press mode controller: poll step
// Combinational next state and result for one switch poll.
// ----------------------------------------------------------------------------
`default_nettype none

module spmc_step (
  input  spmc_pkg::state_t                st,
  input  logic [spmc_pkg::SwW-1:0]        switch_position,
  input  logic [spmc_pkg::TimeW-1:0]      now_ms,
  input  logic [spmc_pkg::CfgW-1:0]       long_press_ms,
  input  logic [spmc_pkg::CfgW-1:0]       led_hold_ms,
  output spmc_pkg::state_t                st_nxt,
  output spmc_pkg::result_t               res
);

  logic [spmc_pkg::SwW-1:0]   sw;
  logic [spmc_pkg::TimeW-1:0] since_hold_end;
  logic [spmc_pkg::TimeW-1:0] held_for;
  logic                       wrote;
  logic [spmc_pkg::LedW-1:0]  pattern;
  logic                       changed;

  assign sw             = (switch_position == spmc_pkg::SW_BAD) ? spmc_pkg::SW_UP
                                                                 : switch_position;
  assign since_hold_end = now_ms - st.hold_end;

  always_comb begin
    st_nxt   = st;
    wrote    = 1'b0;
    pattern  = '0;
    changed  = 1'b0;
    held_for = '0;

    if (!st.primed) begin
      st_nxt.primed  = 1'b1;
      st_nxt.prev_sw = sw;
    end else begin
      // Wrap-safe end of hold: the hold is over once now is not before the end.
      if (st.hold_running && !since_hold_end[spmc_pkg::TimeW-1]) begin
        st_nxt.hold_running = 1'b0;
      end

      if (sw != st.prev_sw) begin
        if (st.prev_sw == spmc_pkg::SW_DOWN) begin
          if (st.short_pending && !st.long_consumed) begin
            st_nxt.note_count = (st.note_count >= spmc_pkg::MAX_NOTES) ? 3'd1
                                : st.note_count + 3'd1;
            if (!st_nxt.hold_running) begin
              st_nxt.change_stamp = now_ms;
              wrote               = 1'b1;
              pattern             = spmc_pkg::bar_of(st_nxt.note_count);
            end
          end
          st_nxt.short_pending = 1'b0;
          st_nxt.long_consumed = 1'b0;
          st_nxt.press_timing  = 1'b0;
          st_nxt.press_start   = '0;
        end
        if (sw == spmc_pkg::SW_DOWN) begin
          st_nxt.press_start   = now_ms;
          st_nxt.press_timing  = 1'b1;
          st_nxt.short_pending = 1'b1;
          st_nxt.long_consumed = 1'b0;
        end else if (sw == spmc_pkg::SW_MID) begin
          st_nxt.limit_on = 1'b1;
          if (!st_nxt.hold_running) begin
            st_nxt.change_stamp = now_ms;
            wrote               = 1'b1;
            pattern             = spmc_pkg::bar_of(st_nxt.note_count);
          end
        end else begin
          st_nxt.limit_on = 1'b0;
          if (!st_nxt.hold_running) begin
            st_nxt.change_stamp = '0;
          end
        end
        st_nxt.prev_sw = sw;
      end

      // The long-press test sees the press state left by any switch change
      // above, so a press that begins on this poll is timed from now.
      held_for = now_ms - st_nxt.press_start;
      if ((sw == spmc_pkg::SW_DOWN) && st_nxt.press_timing && !st_nxt.long_consumed &&
          (held_for >= {{(spmc_pkg::TimeW-spmc_pkg::CfgW){1'b0}}, long_press_ms})) begin
        st_nxt.mode          = (st.mode == spmc_pkg::LAST_MODE) ? '0 : st.mode + 3'd1;
        changed              = 1'b1;
        st_nxt.long_consumed = 1'b1;
        st_nxt.short_pending = 1'b0;
        wrote                = 1'b1;
        pattern              = spmc_pkg::mode_leds(st_nxt.mode);
        st_nxt.hold_running  = 1'b1;
        st_nxt.hold_end      = now_ms +
                               {{(spmc_pkg::TimeW-spmc_pkg::CfgW){1'b0}}, led_hold_ms};
        st_nxt.change_stamp  = now_ms;
      end
    end

    res.led_write       = wrote;
    res.led_bits        = wrote ? pattern : '0;
    res.fixed_length_on = st_nxt.limit_on;
    res.fixed_length    = st_nxt.note_count;
    res.dir_mode        = st_nxt.mode;
    res.mode_pulse      = changed;
    res.hold_busy       = st_nxt.hold_running;
    res.last_change_ms  = st_nxt.change_stamp;
  end

endmodule

`default_nettype wire

// ===== hdl/switch_press_mode_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Switch press mode controller
// Short/long press handling of a three-position switch, one poll at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one switch poll per transaction: switch_position and now_ms.
//   out_ch carries exactly one result transaction for every accepted poll,
//   in order: LED write and pattern, note count and limit, direction mode,
//   mode-changed pulse, hold status and last LED change timestamp.
//   cfg_we/cfg_index/cfg_wdata write long_press_ms (index 0) and led_hold_ms
//   (index 1); write them only while no poll is in flight.
// Latency and throughput:
//   A poll's result is registered and offered on out_ch in the cycle after the
//   poll is accepted. The state update is a single pass of compare and add
//   logic, so one poll can be accepted every cycle unless out_ch stalls.
// Reset (rst_n low, synchronous): state returns to its initial values, the
//   registers to 1000 and 500 ms, and the result register empties. The first
//   poll after reset only records the switch position.
// Stalls: while a result waits and out_ch.ready is low, in_ch.ready is low;
//   nothing is dropped, and the waiting result holds steady.
// ----------------------------------------------------------------------------
`default_nettype none

`include "switch_press_mode_controller_unit_macros.svh"

module switch_press_mode_controller_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  spmc_in_if.sink                        in_ch,
  spmc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [spmc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [spmc_pkg::CfgW-1:0]      cfg_wdata
);

  spmc_pkg::state_t          st_r;
  spmc_pkg::state_t          st_nxt;
  spmc_pkg::result_t         res_nxt;
  spmc_pkg::result_t         res_r;
  logic                      out_valid_r;
  logic [spmc_pkg::CfgW-1:0] long_press_r;
  logic [spmc_pkg::CfgW-1:0] led_hold_r;
  logic                      in_ready;
  logic                      in_accept;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  spmc_step u_step (
    .st              (st_r),
    .switch_position (in_ch.switch_position),
    .now_ms          (in_ch.now_ms),
    .long_press_ms   (long_press_r),
    .led_hold_ms     (led_hold_r),
    .st_nxt          (st_nxt),
    .res             (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= spmc_pkg::LONG_PRESS_RST;
      led_hold_r   <= spmc_pkg::LED_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        spmc_pkg::REG_LONG_PRESS: long_press_r <= cfg_wdata;
        spmc_pkg::REG_LED_HOLD:   led_hold_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.primed        <= 1'b0;
      st_r.prev_sw       <= spmc_pkg::SW_UP;
      st_r.short_pending <= 1'b0;
      st_r.long_consumed <= 1'b0;
      st_r.press_timing  <= 1'b0;
      st_r.press_start   <= '0;
      st_r.note_count    <= spmc_pkg::MAX_NOTES;
      st_r.limit_on      <= 1'b0;
      st_r.mode          <= '0;
      st_r.hold_running  <= 1'b0;
      st_r.hold_end      <= '0;
      st_r.change_stamp  <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      if (in_accept) begin
        st_r <= st_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.led_write       = res_r.led_write;
  assign out_ch.led_bits        = res_r.led_bits;
  assign out_ch.fixed_length_on = res_r.fixed_length_on;
  assign out_ch.fixed_length    = res_r.fixed_length;
  assign out_ch.dir_mode        = res_r.dir_mode;
  assign out_ch.mode_pulse      = res_r.mode_pulse;
  assign out_ch.hold_busy       = res_r.hold_busy;
  assign out_ch.last_change_ms  = res_r.last_change_ms;

  // A long press always writes its mode pattern and starts a hold.
  `SPMC_ASSERT_SAME(a_mode_change_writes, out_valid_r && res_r.mode_pulse, res_r.led_write && res_r.hold_busy, "mode change without LED write and hold")

  // Every accepted transaction leaves a result waiting in the next cycle.
  `SPMC_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_r, "accepted poll produced no result")

  // The note count never leaves its 1 to 6 range.
  `SPMC_ASSERT_SAME(a_note_count_range, 1'b1, (st_r.note_count != 3'd0) && (st_r.note_count <= spmc_pkg::MAX_NOTES), "note count out of range")

  // State only moves on an accepted transaction.
  `SPMC_ASSERT_NEXT(a_state_holds, !in_accept, $stable(st_r), "state changed without a poll")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Switch press mode controller testbench
// Sends switch polls through the valid/ready input channel. The table of
// directed polls comes first, followed by random press gestures under several
// register settings. Results are checked against typed rows or a cycle-free
// model of the press logic, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module tb;

  typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic                               typed;
    logic [spmc_pkg::SwW-1:0]           sw;
    logic [spmc_pkg::CfgIdxW-1:0]       reg_idx;
    logic [spmc_pkg::TimeW-1:0]         value;
    spmc_pkg::result_t                  exp;
  } row_t;

  localparam spmc_pkg::result_t RESULT_IDLE =
    '{1'b0, 6'h00, 1'b0, 3'd6, 3'd0, 1'b0, 1'b0, 32'd0};
  localparam spmc_pkg::result_t RESULT_NONE = '0;

  localparam logic [spmc_pkg::LedW-1:0] MODE_PATTERNS [0:6] = '{
    6'b000001, 6'b010000, 6'b000011, 6'b110000, 6'b010010, 6'b100001, 6'b011001
  };

  localparam int NUM_ROWS = 26;
  localparam row_t DIRECTED [0:NUM_ROWS-1] = '{
    '{ROW_POLL, 1'b1, spmc_pkg::SW_BAD,  spmc_pkg::REG_LONG_PRESS, 32'hFFFF_FFFF, RESULT_IDLE},
    '{ROW_POLL, 1'b1, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd0,         RESULT_IDLE},
    '{ROW_POLL, 1'b1, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd999,       RESULT_IDLE},
    '{ROW_POLL, 1'b1, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd1000,
      '{1'b1, 6'b010000, 1'b0, 3'd6, 3'd1, 1'b1, 1'b1, 32'd1000}},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd1200, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_UP,   spmc_pkg::REG_LONG_PRESS, 32'd1300, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_MID,  spmc_pkg::REG_LONG_PRESS, 32'd1500, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd1600, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_MID,  spmc_pkg::REG_LONG_PRESS, 32'd1700, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd1800, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_UP,   spmc_pkg::REG_LONG_PRESS, 32'd1900, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd2000, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_MID,  spmc_pkg::REG_LONG_PRESS, 32'd2100, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd2200, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_UP,   spmc_pkg::REG_LONG_PRESS, 32'd2300, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd2400, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_MID,  spmc_pkg::REG_LONG_PRESS, 32'd2500, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd2600, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_UP,   spmc_pkg::REG_LONG_PRESS, 32'd2700, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd2800, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_UP,   spmc_pkg::REG_LONG_PRESS, 32'd2900, RESULT_NONE},
    '{ROW_CFG,  1'b0, spmc_pkg::SW_UP,   spmc_pkg::REG_LONG_PRESS, 32'd1,    RESULT_NONE},
    '{ROW_CFG,  1'b0, spmc_pkg::SW_UP,   spmc_pkg::REG_LED_HOLD,   32'd0,    RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'hFFFF_FFFF, RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_DOWN, spmc_pkg::REG_LONG_PRESS, 32'd0,    RESULT_NONE},
    '{ROW_POLL, 1'b0, spmc_pkg::SW_UP,   spmc_pkg::REG_LONG_PRESS, 32'd0,    RESULT_NONE}
  };

  localparam int PHASES     = 5;
  localparam int PHASE_POLLS = 330;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [spmc_pkg::CfgIdxW-1:0] cfg_index;
  logic [spmc_pkg::CfgW-1:0]    cfg_wdata;

  spmc_in_if  in_ch ();
  spmc_out_if out_ch ();

  switch_press_mode_controller_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Model copy of the controller state and registers.
  logic [spmc_pkg::CfgW-1:0]   m_long_ms = spmc_pkg::LONG_PRESS_RST;
  logic [spmc_pkg::CfgW-1:0]   m_hold_ms = spmc_pkg::LED_HOLD_RST;
  logic                        m_primed = 1'b0;
  logic [spmc_pkg::SwW-1:0]    m_prev_sw = spmc_pkg::SW_UP;
  logic                        m_short_armed = 1'b0;
  logic                        m_long_done = 1'b0;
  logic                        m_timing = 1'b0;
  logic [spmc_pkg::TimeW-1:0]  m_press_t0 = '0;
  logic [spmc_pkg::CountW-1:0] m_notes = spmc_pkg::MAX_NOTES;
  logic                        m_limit = 1'b0;
  logic [spmc_pkg::ModeW-1:0]  m_mode = '0;
  logic                        m_hold_on = 1'b0;
  logic [spmc_pkg::TimeW-1:0]  m_hold_end = '0;
  logic [spmc_pkg::TimeW-1:0]  m_stamp = '0;

  spmc_pkg::result_t pending_results [$];
  logic [spmc_pkg::TimeW-1:0] t_now = '0;

  int polls_sent = 0;
  int results_checked = 0;
  int long_presses = 0;
  int reg_writes = 0;
  int failures = 0;
  int send_free = 0;
  int recv_free = 0;
  int recv_stall = 0;

  function automatic logic [spmc_pkg::LedW-1:0] led_bar(input logic [spmc_pkg::CountW-1:0] n);
    logic [spmc_pkg::CountW-1:0] k;
    k = (n < 3'd1 || n > spmc_pkg::MAX_NOTES) ? spmc_pkg::MAX_NOTES : n;
    return 6'h3f >> (spmc_pkg::MAX_NOTES - k);
  endfunction

  function automatic spmc_pkg::result_t predict_poll(
      input logic [spmc_pkg::SwW-1:0] sw_raw, input logic [spmc_pkg::TimeW-1:0] now);
    spmc_pkg::result_t r;
    logic [spmc_pkg::SwW-1:0] sw;
    logic [spmc_pkg::TimeW-1:0] since_end;
    logic [spmc_pkg::TimeW-1:0] held;
    r = '0;
    sw = (sw_raw == spmc_pkg::SW_BAD) ? spmc_pkg::SW_UP : sw_raw;
    if (!m_primed) begin
      m_primed = 1'b1;
      m_prev_sw = sw;
    end else begin
      // The hold is over once now has reached its end, modulo 2^32.
      since_end = now - m_hold_end;
      if (m_hold_on && !since_end[spmc_pkg::TimeW-1]) m_hold_on = 1'b0;
      if (sw != m_prev_sw) begin
        if (m_prev_sw == spmc_pkg::SW_DOWN) begin
          if (m_short_armed && !m_long_done) begin
            m_notes = (m_notes >= spmc_pkg::MAX_NOTES) ? 3'd1 : m_notes + 3'd1;
            if (!m_hold_on) begin
              m_stamp = now;
              r.led_write = 1'b1;
              r.led_bits = led_bar(m_notes);
            end
          end
          m_short_armed = 1'b0;
          m_long_done = 1'b0;
          m_timing = 1'b0;
          m_press_t0 = '0;
        end
        if (sw == spmc_pkg::SW_DOWN) begin
          m_press_t0 = now;
          m_timing = 1'b1;
          m_short_armed = 1'b1;
          m_long_done = 1'b0;
        end else if (sw == spmc_pkg::SW_MID) begin
          m_limit = 1'b1;
          if (!m_hold_on) begin
            m_stamp = now;
            r.led_write = 1'b1;
            r.led_bits = led_bar(m_notes);
          end
        end else begin
          m_limit = 1'b0;
          if (!m_hold_on) m_stamp = '0;
        end
        m_prev_sw = sw;
      end
      held = now - m_press_t0;
      if (sw == spmc_pkg::SW_DOWN && m_timing && !m_long_done &&
          held >= {16'd0, m_long_ms}) begin
        m_mode = (m_mode == spmc_pkg::LAST_MODE) ? 3'd0 : m_mode + 3'd1;
        r.mode_pulse = 1'b1;
        m_long_done = 1'b1;
        m_short_armed = 1'b0;
        r.led_write = 1'b1;
        r.led_bits = MODE_PATTERNS[m_mode];
        m_hold_on = 1'b1;
        m_hold_end = now + {16'd0, m_hold_ms};
        m_stamp = now;
      end
    end
    r.fixed_length_on = m_limit;
    r.fixed_length = m_notes;
    r.dir_mode = m_mode;
    r.hold_busy = m_hold_on;
    r.last_change_ms = m_stamp;
    return r;
  endfunction

  function automatic string fmt_result(input spmc_pkg::result_t r);
    return $sformatf("wr=%0d pat=%b lim=%0d len=%0d mode=%0d chg=%0d hold=%0d stamp=%h",
                     r.led_write, r.led_bits, r.fixed_length_on, r.fixed_length,
                     r.dir_mode, r.mode_pulse, r.hold_busy, r.last_change_ms);
  endfunction

  task automatic report_failure(input string what, input spmc_pkg::result_t e,
                                input spmc_pkg::result_t a);
    failures++;
    if (failures <= 10) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected %s", fmt_result(e));
      $display("  actual   %s", fmt_result(a));
    end
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap(inout int free_run);
    int unsigned r;
    if (free_run > 0) begin
      free_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      free_run = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Result channel: random backpressure and checking in one process.
  initial begin
    spmc_pkg::result_t got;
    spmc_pkg::result_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.led_write, out_ch.led_bits, out_ch.fixed_length_on,
                out_ch.fixed_length, out_ch.dir_mode, out_ch.mode_pulse,
                out_ch.hold_busy, out_ch.last_change_ms};
        if (pending_results.size() == 0) begin
          report_failure("result transaction with nothing expected", RESULT_NONE, got);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.led_write !== want.led_write || got.led_bits !== want.led_bits ||
              got.fixed_length_on !== want.fixed_length_on ||
              got.fixed_length !== want.fixed_length || got.dir_mode !== want.dir_mode ||
              got.mode_pulse !== want.mode_pulse ||
              got.hold_busy !== want.hold_busy ||
              got.last_change_ms !== want.last_change_ms)
            report_failure($sformatf("mismatch on result %0d", results_checked), want, got);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        recv_stall = pick_gap(recv_free);
        if (recv_stall > 0) begin
          recv_stall--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_poll(input logic [spmc_pkg::SwW-1:0] sw,
                           input logic [spmc_pkg::TimeW-1:0] now,
                           input logic typed, input spmc_pkg::result_t typed_result);
    int gap;
    spmc_pkg::result_t r;
    gap = pick_gap(send_free);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.switch_position <= sw;
    in_ch.now_ms <= now;
    do @(posedge clk); while (!in_ch.ready);
    r = predict_poll(sw, now);
    if (r.mode_pulse) long_presses++;
    pending_results.push_back(typed ? typed_result : r);
    polls_sent++;
  endtask

  task automatic timed_poll(input logic [spmc_pkg::SwW-1:0] sw,
                            input logic [spmc_pkg::TimeW-1:0] dt);
    t_now = t_now + dt;
    send_poll(sw, t_now, 1'b0, RESULT_NONE);
  endtask

  // Registers change only with the channel quiet and every result drained.
  task automatic write_reg(input logic [spmc_pkg::CfgIdxW-1:0] idx,
                           input logic [spmc_pkg::CfgW-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == spmc_pkg::REG_LONG_PRESS) m_long_ms = val;
    else m_hold_ms = val;
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [spmc_pkg::SwW-1:0] release_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return spmc_pkg::SW_UP;
    if (r < 90) return spmc_pkg::SW_MID;
    return spmc_pkg::SW_BAD;
  endfunction

  task automatic press_gesture(input bit go_long);
    logic [spmc_pkg::TimeW-1:0] lim;
    logic [spmc_pkg::TimeW-1:0] hold;
    logic [spmc_pkg::TimeW-1:0] t0;
    logic [spmc_pkg::TimeW-1:0] total;
    logic [spmc_pkg::TimeW-1:0] dt;
    int unsigned n;
    lim = {16'd0, m_long_ms};
    hold = {16'd0, m_hold_ms};
    timed_poll(spmc_pkg::SW_DOWN, $urandom_range(1, lim));
    t0 = t_now;
    n = $urandom_range(0, 2);
    if (!go_long) begin
      total = $urandom_range(0, lim - 1);
      repeat (n) send_poll(spmc_pkg::SW_DOWN, t0 + $urandom_range(0, total), 1'b0,
                           RESULT_NONE);
      t_now = t0 + total;
    end else begin
      repeat (n) send_poll(spmc_pkg::SW_DOWN, t0 + $urandom_range(0, lim - 1), 1'b0,
                           RESULT_NONE);
      // Sometimes one poll just short of the threshold, then one at or past it.
      if ($urandom_range(0, 2) == 0)
        send_poll(spmc_pkg::SW_DOWN, t0 + lim - 1, 1'b0, RESULT_NONE);
      t_now = t0 + lim;
      if ($urandom_range(0, 2) != 0) t_now = t_now + $urandom_range(0, 50);
      send_poll(spmc_pkg::SW_DOWN, t_now, 1'b0, RESULT_NONE);
      repeat ($urandom_range(0, 2)) timed_poll(spmc_pkg::SW_DOWN, $urandom_range(0, lim));
    end
    case ($urandom_range(0, 2))
      0:       dt = hold;
      1:       dt = $urandom_range(0, hold + 2);
      default: dt = $urandom_range(0, lim);
    endcase
    timed_poll(release_position(), dt);
  endtask

  task automatic run_gesture();
    int unsigned pick;
    logic [spmc_pkg::SwW-1:0] sw;
    logic [spmc_pkg::TimeW-1:0] lim;
    pick = $urandom_range(0, 99);
    lim = {16'd0, m_long_ms};
    if (pick < 35) begin
      press_gesture(1'b0);
    end else if (pick < 65) begin
      press_gesture(1'b1);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0) sw = spmc_pkg::SW_BAD;
        else if ($urandom_range(0, 1) == 0) sw = spmc_pkg::SW_UP;
        else sw = spmc_pkg::SW_MID;
        timed_poll(sw, $urandom_range(0, {16'd0, m_hold_ms} + 2));
      end
    end else if (pick < 88) begin
      // Long press straddling the timestamp wrap.
      t_now = 32'hFFFF_FFFF - $urandom_range(0, 2 * lim);
      press_gesture(1'b1);
    end else begin
      repeat ($urandom_range(1, 3)) begin
        sw = spmc_pkg::SwW'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) t_now = $urandom;
        else t_now = t_now + $urandom_range(0, 100) - 50;
        send_poll(sw, t_now, 1'b0, RESULT_NONE);
      end
    end
  endtask

  initial begin
    int start_polls;
    logic [spmc_pkg::CfgW-1:0] lp;
    logic [spmc_pkg::CfgW-1:0] lh;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = spmc_pkg::REG_LONG_PRESS;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.switch_position = spmc_pkg::SW_UP;
    in_ch.now_ms = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG)
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value[spmc_pkg::CfgW-1:0]);
      else
        send_poll(DIRECTED[i].sw, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].exp);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lp = 16'd1;     lh = 16'd0;     end
        1: begin lp = 16'hFFFF;  lh = 16'hFFFF;  end
        2: begin
          lp = spmc_pkg::CfgW'($urandom_range(1, 300));
          lh = spmc_pkg::CfgW'($urandom_range(0, 300));
        end
        3: begin
          lp = spmc_pkg::CfgW'($urandom_range(1, 65535));
          lh = spmc_pkg::CfgW'($urandom);
        end
        default: begin lp = spmc_pkg::LONG_PRESS_RST; lh = spmc_pkg::LED_HOLD_RST; end
      endcase
      write_reg(spmc_pkg::REG_LONG_PRESS, lp);
      write_reg(spmc_pkg::REG_LED_HOLD, lh);
      if ($urandom_range(0, 1) == 0) t_now = $urandom;
      start_polls = polls_sent;
      while (polls_sent - start_polls < PHASE_POLLS) run_gesture();
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d polls over %0d register writes; %0d results checked.",
             polls_sent, reg_writes, results_checked);
    $display("Model saw %0d long presses; %0d failures.", long_presses, failures);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
